>>> design/fpw_pkg.sv
package fpw_pkg;

   localparam int unsigned FPW_MAX_SAMPLES = 1024;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 2'd1;

   localparam logic [15:0] SCALE_RESET = 16'd4096;
   localparam logic [10:0] COUNT_RESET = 11'd1024;

   localparam int unsigned TRIG_W = 31;
   localparam logic [TRIG_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

   typedef struct packed {
      logic              req_type;
      logic [9:0]        sample_index;
      logic signed [15:0] amp_re;
      logic signed [15:0] amp_im;
      logic signed [15:0] position;
      logic signed [15:0] wavenumber;
   } req_type_t_type;

   typedef struct packed {
      logic [31:0] density;
      logic        saturated;
   } rsp_data_type;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic signed [15:0] pos;
   } sample_type;

   // operands carried down the series cells
   typedef struct packed {
      logic               valid;
      logic signed [15:0] ar;
      logic signed [15:0] ai;
      logic [1:0]         quad;
      logic               fold;
      logic [TRIG_W-1:0]  a;
      logic [TRIG_W-1:0]  t;
      logic [TRIG_W-1:0]  pc;
      logic [TRIG_W-1:0]  ps;
   } trig_type;

   typedef struct packed {
      logic               valid;
      logic signed [32:0] re_c;
      logic signed [32:0] im_s;
      logic signed [32:0] im_c;
      logic signed [32:0] re_s;
   } prod_type;

   // Q1.30 product, rounded
   function automatic logic [TRIG_W-1:0] qmul30(input logic [TRIG_W-1:0] x,
                                                input logic [TRIG_W-1:0] y);
      logic [62:0] p;
      p = 63'(x) * 63'(y) + 63'(32'h2000_0000);
      return p[60:30];
   endfunction

endpackage

>>> design/fpw_ram.sv
module fpw_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/fpw_phase.sv
module fpw_phase (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fpw_pkg::sample_type sample,
   input  logic signed [15:0] wavenumber,
   output fpw_pkg::trig_type  phase_out
);
   import fpw_pkg::*;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [15:0] ar1_ff, ai1_ff, ar2_ff, ai2_ff, ar3_ff, ai3_ff, ar4_ff, ai4_ff;
   logic signed [31:0] theta1_ff;
   logic [47:0]        turns2_ff;
   logic [1:0]         quad3_ff, quad4_ff;
   logic               fold3_ff, fold4_ff;
   logic [13:0]        w3_ff;
   logic [TRIG_W-1:0]  a4_ff;
   trig_type           out_ff;

   logic signed [31:0] theta_in;
   logic signed [61:0] turns_in;
   logic [47:0]        biased;
   logic [15:0]        u;
   logic [13:0]        v;
   logic               fold_in;
   logic [13:0]        w_in;
   logic [46:0]        aw;

   always_comb begin
      theta_in = sample.pos * wavenumber;
      turns_in = theta1_ff * $signed({1'b0, INV_TWO_PI_Q32});
      biased   = turns2_ff + 48'h0000_8000_0000;
      u        = biased[47:32];
      v        = u[13:0];
      fold_in  = v > 14'h2000;
      // fold past an eighth turn onto the complement
      w_in     = fold_in ? 14'(15'h4000 - 15'(v)) : v;
      aw       = 47'(w3_ff) * 47'(TWO_PI_Q30) + 47'(16'h8000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         out_ff.valid <= v4_ff;
      end
      ar1_ff <= sample.re;
      ai1_ff <= sample.im;
      theta1_ff <= theta_in;
      ar2_ff <= ar1_ff;
      ai2_ff <= ai1_ff;
      turns2_ff <= turns_in[47:0];
      ar3_ff <= ar2_ff;
      ai3_ff <= ai2_ff;
      quad3_ff <= u[15:14];
      fold3_ff <= fold_in;
      w3_ff <= w_in;
      ar4_ff <= ar3_ff;
      ai4_ff <= ai3_ff;
      quad4_ff <= quad3_ff;
      fold4_ff <= fold3_ff;
      a4_ff <= aw[46:16];
      out_ff.ar <= ar4_ff;
      out_ff.ai <= ai4_ff;
      out_ff.quad <= quad4_ff;
      out_ff.fold <= fold4_ff;
      out_ff.a <= a4_ff;
      out_ff.t <= qmul30(a4_ff, a4_ff);
      out_ff.pc <= Q30_ONE;
      out_ff.ps <= Q30_ONE;
   end

   assign phase_out = out_ff;
endmodule

>>> design/fpw_cell.sv
module fpw_cell #(
   parameter int unsigned DIV_C = 2,
   parameter int unsigned DIV_S = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  fpw_pkg::trig_type cell_in,
   output fpw_pkg::trig_type cell_out
);
   import fpw_pkg::*;

   localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / DIV_C);
   localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / DIV_S);

   trig_type          s1_ff, s2_ff, out_ff;
   trig_type          s1_in, out_in;
   logic [TRIG_W-1:0] q0c_ff, q0s_ff;
   logic [62:0]       mc, ms;
   logic [31:0]       rem_c, rem_s;
   logic [TRIG_W-1:0] qc, qs;

   always_comb begin
      s1_in    = cell_in;
      s1_in.pc = qmul30(cell_in.t, cell_in.pc);
      s1_in.ps = qmul30(cell_in.t, cell_in.ps);
      mc    = 63'(s1_ff.pc) * 63'(RECIP_C);
      ms    = 63'(s1_ff.ps) * 63'(RECIP_S);
      rem_c = 32'(s2_ff.pc) - 32'(q0c_ff) * DIV_C;
      rem_s = 32'(s2_ff.ps) - 32'(q0s_ff) * DIV_S;
      // reciprocal estimate is low by at most one
      qc    = q0c_ff + TRIG_W'(rem_c >= DIV_C);
      qs    = q0s_ff + TRIG_W'(rem_s >= DIV_S);
      out_in    = s2_ff;
      out_in.pc = Q30_ONE - qc;
      out_in.ps = Q30_ONE - qs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         s1_ff  <= s1_in;
         s2_ff  <= s1_ff;
         out_ff <= out_in;
      end
      q0c_ff <= mc[62:32];
      q0s_ff <= ms[62:32];
   end

   assign cell_out = out_ff;
endmodule

>>> design/fpw_rotor.sv
module fpw_rotor (
   input  logic              clock,
   input  logic              reset,
   input  fpw_pkg::trig_type rot_in,
   output fpw_pkg::prod_type rot_out
);
   import fpw_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   trig_type           r1_ff;
   trig_type           r1_in;
   logic               v2_ff;
   logic signed [15:0] ar2_ff, ai2_ff;
   logic signed [16:0] co2_ff, si2_ff;
   prod_type           out_ff;

   logic [TRIG_W-1:0]  rc, rs;
   logic signed [16:0] c, s, co, si;

   always_comb begin
      r1_in    = rot_in;
      r1_in.ps = qmul30(rot_in.a, rot_in.ps);
      rc = r1_ff.pc + TRIG_W'(16'h4000);
      rs = r1_ff.ps + TRIG_W'(16'h4000);
      c  = $signed({1'b0, rc[30:15]});
      s  = $signed({1'b0, rs[30:15]});
      if (r1_ff.fold) begin
         c = $signed({1'b0, rs[30:15]});
         s = $signed({1'b0, rc[30:15]});
      end
      case (r1_ff.quad)
         QUAD_0: begin co = c;  si = s;  end
         QUAD_1: begin co = -s; si = c;  end
         QUAD_2: begin co = -c; si = -s; end
         default: begin co = s; si = -c; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff.valid  <= 1'b0;
         v2_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         r1_ff <= r1_in;
         v2_ff <= r1_ff.valid;
         out_ff.valid <= v2_ff;
      end
      ar2_ff <= r1_ff.ar;
      ai2_ff <= r1_ff.ai;
      co2_ff <= co;
      si2_ff <= si;
      out_ff.re_c <= ar2_ff * co2_ff;
      out_ff.im_s <= ai2_ff * si2_ff;
      out_ff.im_c <= ai2_ff * co2_ff;
      out_ff.re_s <= ar2_ff * si2_ff;
   end

   assign rot_out = out_ff;
endmodule

>>> design/fourier_power_at_wavenumber_unit.sv
// Power of a stored complex wave at one wavenumber. Load transfers (req_type 0) write one
// sample into a MAX_SAMPLES-entry store and give no response. A query transfer (req_type 1)
// sums sample * exp(-i k x) over the first sample_count entries, scales the sum and returns
// its squared magnitude, clipped with a flag. A query reads one sample per cycle from the
// store's single read port and pushes it through the phase unit, a chain of four series
// cells and the rotator; req_ready is low from the query's acceptance until its response
// is loaded into the output register. Loads are taken back to back whenever no query is
// running, also while a response waits.
module fourier_power_at_wavenumber_unit #(
   parameter int unsigned MAX_SAMPLES = fpw_pkg::FPW_MAX_SAMPLES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fpw_pkg::req_type_t_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fpw_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_wr_en,
   input  logic [fpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_wdata
);
   import fpw_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_SAMPLES);
   localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned ACC_W = 33 + $clog2(MAX_SAMPLES);
   localparam int unsigned SW    = ACC_W + 17;
   localparam int unsigned ZW    = SW - 26;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RUN    = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_SCALE  = 7'b0001000,
      ST_ROUND  = 7'b0010000,
      ST_SQUARE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [15:0]           scale_ff;
   logic [10:0]           count_ff;
   logic signed [15:0]    k_ff;
   logic [CW-1:0]         n_ff, j_ff, j_in, n_in;
   logic [CW-1:0]         flight_ff, flight_in;
   logic                  rd_valid_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [SW-1:0]  pr_re_ff, pr_im_ff;
   logic [23:0]           m_re_ff, m_im_ff;
   logic                  big_ff;
   logic [47:0]           sq_re_ff, sq_im_ff;
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_ff;

   logic                  accept, issue, load_wr, rsp_load;
   sample_type            wr_sample, rd_sample;
   logic [$bits(sample_type)-1:0] rd_word;
   trig_type              chain [5];
   prod_type              prod;
   logic signed [SW-1:0]  rnd_re, rnd_im;
   logic signed [ZW-1:0]  z_re, z_im;
   logic [ZW-1:0]         a_re, a_im;
   logic [48:0]           esum;
   logic [32:0]           dens;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_wr   = accept && (req_data.req_type == REQ_LOAD)
                      && (32'(req_data.sample_index) < MAX_SAMPLES);
   assign issue     = (state_ff == ST_RUN);
   assign n_in      = (32'(count_ff) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : CW'(count_ff);

   assign wr_sample.re  = req_data.amp_re;
   assign wr_sample.im  = req_data.amp_im;
   assign wr_sample.pos = req_data.position;

   fpw_ram #(
      .WIDTH($bits(sample_type)),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (AW'(req_data.sample_index)),
      .wr_data (wr_sample),
      .rd_en   (issue),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (rd_word)
   );
   assign rd_sample = rd_word;

   fpw_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_valid_ff),
      .sample     (rd_sample),
      .wavenumber (k_ff),
      .phase_out  (chain[0])
   );

   fpw_cell #(.DIV_C(56), .DIV_S(72)) u_cell0 (
      .clock(clock), .reset(reset), .cell_in(chain[0]), .cell_out(chain[1]));
   fpw_cell #(.DIV_C(30), .DIV_S(42)) u_cell1 (
      .clock(clock), .reset(reset), .cell_in(chain[1]), .cell_out(chain[2]));
   fpw_cell #(.DIV_C(12), .DIV_S(20)) u_cell2 (
      .clock(clock), .reset(reset), .cell_in(chain[2]), .cell_out(chain[3]));
   fpw_cell #(.DIV_C(2), .DIV_S(6)) u_cell3 (
      .clock(clock), .reset(reset), .cell_in(chain[3]), .cell_out(chain[4]));

   fpw_rotor u_rotor (
      .clock   (clock),
      .reset   (reset),
      .rot_in  (chain[4]),
      .rot_out (prod)
   );

   always_comb begin
      rnd_re = pr_re_ff + SW'(32'h0200_0000);
      rnd_im = pr_im_ff + SW'(32'h0200_0000);
      z_re   = ZW'(rnd_re >>> 26);
      z_im   = ZW'(rnd_im >>> 26);
      a_re   = z_re[ZW-1] ? ZW'(-z_re) : ZW'(z_re);
      a_im   = z_im[ZW-1] ? ZW'(-z_im) : ZW'(z_im);
      esum   = 49'(sq_re_ff) + 49'(sq_im_ff) + 49'(16'h8000);
      dens   = esum[48:16];
      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      flight_in = flight_ff + CW'(issue) - CW'(prod.valid);
      j_in      = j_ff;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            j_in = '0;
            if (accept && req_data.req_type == REQ_QUERY) begin
               state_in = (n_in == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            j_in = j_ff + CW'(1);
            if (j_in == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (flight_ff == '0 && !rd_valid_ff) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= SCALE_RESET;
         count_ff     <= COUNT_RESET;
         flight_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         flight_ff   <= flight_in;
         rd_valid_ff <= issue;
         if (csr_wr_en && csr_index == CSR_SCALE) begin
            scale_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata[10:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      j_ff <= j_in;
      if (accept) begin
         k_ff      <= req_data.wavenumber;
         n_ff      <= n_in;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod.valid) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod.re_c) + ACC_W'(prod.im_s);
         acc_im_ff <= acc_im_ff + ACC_W'(prod.im_c) - ACC_W'(prod.re_s);
      end
      pr_re_ff <= acc_re_ff * $signed({1'b0, scale_ff});
      pr_im_ff <= acc_im_ff * $signed({1'b0, scale_ff});
      m_re_ff  <= a_re[23:0];
      m_im_ff  <= a_im[23:0];
      if (state_ff == ST_ROUND) begin
         big_ff <= (a_re >= ZW'(25'h100_0000)) || (a_im >= ZW'(25'h100_0000));
      end
      sq_re_ff <= m_re_ff * m_re_ff;
      sq_im_ff <= m_im_ff * m_im_ff;
      if (rsp_load) begin
         rsp_ff.saturated <= big_ff || dens[32];
         rsp_ff.density   <= (big_ff || dens[32]) ? 32'hFFFF_FFFF : dens[31:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> design/fpw_checker.sv
module fpw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input fpw_pkg::req_type_t_type         req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input fpw_pkg::rsp_data_type           rsp_data,
   input logic                            csr_wr_en,
   input logic [fpw_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [15:0]                     csr_wdata
);
   import fpw_pkg::*;

   logic unused_ok;
   assign unused_ok = csr_wr_en ^ (^csr_index) ^ (^csr_wdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.density == 32'hFFFF_FFFF)
      else $error("saturated response not clipped");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type == REQ_QUERY |=> !req_ready)
      else $error("query transfer did not hold off the next item");
endmodule

bind fourier_power_at_wavenumber_unit fpw_checker u_fpw_checker (.*);

>>> verif/fourier_power_at_wavenumber_unit_tb.sv
`timescale 1ns / 1ps

module fourier_power_at_wavenumber_unit_tb;
   import fpw_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // Expected densities, predicted from the loaded samples and the register copies.
   class power_scoreboard;
      logic signed [15:0] re_mem [FPW_MAX_SAMPLES];
      logic signed [15:0] im_mem [FPW_MAX_SAMPLES];
      logic signed [15:0] pos_mem [FPW_MAX_SAMPLES];
      logic [15:0] scale_r;
      logic [10:0] count_r;
      rsp_data_type density_q[$];

      function new();
         scale_r = SCALE_RESET;
         count_r = COUNT_RESET;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] value);
         if (idx == CSR_SCALE) scale_r = value;
         else if (idx == CSR_COUNT) count_r = value[10:0];
      endfunction

      function int pending();
         return density_q.size();
      endfunction

      static function longint unsigned mul_q30(longint unsigned x, longint unsigned y);
         return (x * y + (64'd1 << 29)) >> 30;
      endfunction

      static function void turn_trig(logic [15:0] u, output longint co, output longint si);
         longint unsigned one, w, a, t, pc, ps;
         longint c, s, tmp;
         logic fold;
         one = 64'd1 << 30;
         fold = u[13:0] > 14'h2000;
         w = fold ? 64'd16384 - u[13:0] : u[13:0];
         a = (w * 64'd6746518852 + 64'd32768) >> 16;
         t = mul_q30(a, a);
         pc = one - mul_q30(t, one) / 56;
         pc = one - mul_q30(t, pc) / 30;
         pc = one - mul_q30(t, pc) / 12;
         pc = one - mul_q30(t, pc) / 2;
         ps = one - mul_q30(t, one) / 72;
         ps = one - mul_q30(t, ps) / 42;
         ps = one - mul_q30(t, ps) / 20;
         ps = one - mul_q30(t, ps) / 6;
         ps = mul_q30(a, ps);
         c = longint'((pc + 64'd16384) >> 15);
         s = longint'((ps + 64'd16384) >> 15);
         if (fold) begin
            tmp = c; c = s; s = tmp;
         end
         case (u[15:14])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
         endcase
      endfunction

      function rsp_data_type power_at(logic signed [15:0] wn);
         longint acc_re, acc_im, k, theta, turns, zr, zi, co, si, ar, ai;
         logic [63:0] tt;
         longint unsigned e, d;
         int n;
         rsp_data_type res;
         acc_re = 0;
         acc_im = 0;
         k = wn;
         n = (count_r > FPW_MAX_SAMPLES) ? FPW_MAX_SAMPLES : count_r;
         for (int j = 0; j < n; j++) begin
            ar = re_mem[j];
            ai = im_mem[j];
            theta = k * longint'(pos_mem[j]);
            turns = theta * 64'sd683565276;
            tt = turns + 64'sh8000_0000;
            turn_trig(tt[47:32], co, si);
            acc_re += ar * co + ai * si;
            acc_im += ai * co - ar * si;
         end
         zr = (acc_re * longint'(scale_r) + (64'sd1 << 25)) >>> 26;
         zi = (acc_im * longint'(scale_r) + (64'sd1 << 25)) >>> 26;
         if (zr < 0) zr = -zr;
         if (zi < 0) zi = -zi;
         res.saturated = 1'b0;
         if (zr >= (64'sd1 << 24) || zi >= (64'sd1 << 24)) begin
            d = 64'hFFFF_FFFF;
            res.saturated = 1'b1;
         end else begin
            e = zr * zr + zi * zi;
            d = (e + 64'd32768) >> 16;
            if (d > 64'hFFFF_FFFF) begin
               d = 64'hFFFF_FFFF;
               res.saturated = 1'b1;
            end
         end
         res.density = d[31:0];
         return res;
      endfunction

      function void note_input(req_type_t_type r);
         if (r.req_type == REQ_LOAD) begin
            re_mem[r.sample_index] = r.amp_re;
            im_mem[r.sample_index] = r.amp_im;
            pos_mem[r.sample_index] = r.position;
         end else begin
            density_q.push_back(power_at(r.wavenumber));
         end
      endfunction

      function bit check_result(rsp_data_type got, output string why);
         rsp_data_type want;
         if (density_q.size() == 0) begin
            why = $sformatf("unexpected response density=%h", got.density);
            return 0;
         end
         want = density_q.pop_front();
         why = "";
         if (got.density !== want.density)
            why = $sformatf("density got %h want %h", got.density, want.density);
         if (got.saturated !== want.saturated)
            why = {why, $sformatf(" saturated got %b want %b", got.saturated, want.saturated)};
         return why == "";
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type_t_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_data_type rsp_data;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   power_scoreboard sb;
   int errors;
   int cycles;
   int hold_cnt;
   bit loaded [FPW_MAX_SAMPLES];

   fourier_power_at_wavenumber_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string why);
      errors++;
      $display("[%0d] mismatch: %s", cycles, why);
   endtask

   always @(posedge clock) begin
      string why;
      if (!reset) begin
         cycles++;
         if (req_valid && req_ready) sb.note_input(req_data);
         if (rsp_valid && rsp_ready && !sb.check_result(rsp_data, why)) report_mismatch(why);
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: stretches of varying acceptance, rare stalls, and a long forced hold.
   initial begin
      int pct;
      int stretch_left;
      pct = 100;
      stretch_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_ready = 1'b0;
            hold_cnt--;
         end else begin
            if (stretch_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: pct = 100;
                  2: pct = 80;
                  3: pct = 40;
                  default: pct = 10;
               endcase
               stretch_left = $urandom_range(20, 200);
            end
            stretch_left--;
            if ($urandom_range(0, 499) == 0) hold_cnt = $urandom_range(30, 90);
            rsp_ready = $urandom_range(0, 99) < pct;
         end
      end
   end

   task automatic send_item(req_type_t_type r);
      int g;
      int roll;
      roll = $urandom_range(0, 99);
      g = (roll < 60) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (g > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      if (r.req_type == REQ_LOAD) loaded[r.sample_index] = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, drain every pending response, then let the pipeline settle.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.write_reg(idx, value);
   endtask

   function automatic req_type_t_type make_load(int idx, int re, int im, int pos);
      req_type_t_type r;
      r.req_type = REQ_LOAD;
      r.sample_index = idx[9:0];
      r.amp_re = re[15:0];
      r.amp_im = im[15:0];
      r.position = pos[15:0];
      r.wavenumber = 16'($urandom);
      return r;
   endfunction

   function automatic req_type_t_type make_query(int wn);
      req_type_t_type r;
      r.req_type = REQ_QUERY;
      r.sample_index = 10'($urandom);
      r.amp_re = 16'($urandom);
      r.amp_im = 16'($urandom);
      r.position = 16'($urandom);
      r.wavenumber = wn[15:0];
      return r;
   endfunction

   function automatic int first_missing(int count);
      int n;
      n = (count > FPW_MAX_SAMPLES) ? FPW_MAX_SAMPLES : count;
      for (int j = 0; j < n; j++)
         if (!loaded[j]) return j;
      return -1;
   endfunction

   task automatic run_phase(int items, logic [15:0] scale, int count);
      int miss;
      int hi;
      quiesce();
      write_csr(CSR_SCALE, scale);
      write_csr(CSR_COUNT, count[15:0]);
      hi = (count + 3 > FPW_MAX_SAMPLES - 1) ? FPW_MAX_SAMPLES - 1 : count + 3;
      for (int i = 0; i < items; i++) begin
         miss = first_missing(count);
         if (miss >= 0)
            send_item(make_load(miss, $urandom, $urandom, $urandom));
         else if ($urandom_range(0, 99) < 40)
            send_item(make_query($urandom));
         else if ($urandom_range(0, 99) < 70)
            send_item(make_load($urandom_range(0, hi), $urandom, $urandom, $urandom));
         else
            send_item(make_load($urandom_range(0, FPW_MAX_SAMPLES - 1),
                                $urandom, $urandom, $urandom));
      end
   endtask

   initial begin
      logic [15:0] scale;
      int count;
      sb = new();
      errors = 0;
      cycles = 0;
      hold_cnt = 0;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty sum
      write_csr(CSR_COUNT, 16'd0);
      send_item(make_query(123));
      quiesce();

      // extreme amplitudes summed in phase must clip
      write_csr(CSR_SCALE, 16'hFFFF);
      write_csr(CSR_COUNT, 16'd16);
      for (int j = 0; j < 16; j++)
         send_item(make_load(j, -32768, -32768,
                             (j == 0) ? 32767 : (j == 1) ? -32768 : (j - 8) * 256));
      send_item(make_query(0));
      send_item(make_query(32767));
      send_item(make_query(-32768));
      send_item(make_load(FPW_MAX_SAMPLES - 1, 32767, 32767, 32767));
      send_item(make_query(1));
      quiesce();
      write_csr(CSR_SCALE, 16'd0);
      send_item(make_query(-1));
      quiesce();

      // unused index ignored, count value masked to its width
      write_csr(CSR_UNUSED, 16'hFFFF);
      write_csr(CSR_COUNT, 16'hF810);
      send_item(make_query(77));
      send_item(make_load(3, 32767, -32768, 0));
      send_item(make_query(0));

      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 5))
            0: scale = 16'd0;
            1: scale = 16'hFFFF;
            2: scale = SCALE_RESET;
            default: scale = 16'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: count = 1;
            1: count = $urandom_range(100, 200);
            default: count = $urandom_range(2, 40);
         endcase
         if (p == 3) begin
            quiesce();
            hold_cnt = 400;
         end
         run_phase(45, scale, count);
      end

      // fill the whole store, then query with counts past its end
      quiesce();
      for (int j = 0; j < FPW_MAX_SAMPLES; j++)
         if (!loaded[j]) send_item(make_load(j, $urandom, $urandom, $urandom));
      run_phase(3, 16'($urandom), 2047);
      run_phase(3, 16'hFFFF, 1024);
      run_phase(2, 16'($urandom), 1025);

      quiesce();
      repeat (60) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
